[hw/rtl/wfac_pkg.sv]
// shared types, constants and lookup functions for the frame airtime calculator
package wfac_pkg;

  // field widths
  localparam int MSG_TYPE_W   = 3;
  localparam int BYTE_CNT_W   = 16;
  localparam int DURATION_W   = 30;
  localparam int MODE_W       = 2;
  localparam int RATE_W       = 16;

  // configuration port
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_UCAST  = 2'd1;
  localparam logic [1:0] REG_MCAST  = 2'd2;

  // register reset values
  localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
  localparam logic [RATE_W-1:0] RATE_RESET  = 16'd11000;

  // modulation modes
  localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFDM_A  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DSSS_B  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MIXED   = 2'd3;

  // message types
  localparam logic [MSG_TYPE_W-1:0] MSG_CTS     = 3'd0;
  localparam logic [MSG_TYPE_W-1:0] MSG_UNICAST = 3'd1;
  localparam logic [MSG_TYPE_W-1:0] MSG_RTS_CTS = 3'd2;
  localparam logic [MSG_TYPE_W-1:0] MSG_BCAST   = 3'd3;

  // frame bit counts and scale
  localparam int DATA_HDR_BITS = 272;
  localparam int ACK_BITS      = 112;
  localparam int CTRL_HDR_BITS = 160;
  localparam int KBPS_SCALE    = 1000;
  localparam int BITS_W        = 20;

  // divider geometry: dividend is at most (384 + 8*65535) * 1000 < 2**29
  localparam int DIV_W         = 29;
  localparam int DIV_BPS_DEF   = 4;
  localparam logic [DIV_W-1:0] CTRL_DIVIDEND = DIV_W'(CTRL_HDR_BITS * KBPS_SCALE);

  // fixed overhead in usec, at most sifs + four preambles
  localparam int OVH_W = 10;

  localparam logic [DURATION_W-1:0] DUR_MAX = {DURATION_W{1'b1}};

  // how the control frame quotient enters the sum
  localparam logic [1:0] CTRL_NONE   = 2'd0;
  localparam logic [1:0] CTRL_SINGLE = 2'd1;
  localparam logic [1:0] CTRL_DOUBLE = 2'd2;

  typedef struct packed {
    logic [MSG_TYPE_W-1:0] msg_type;
    logic [BYTE_CNT_W-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [DURATION_W-1:0] duration_usec;
    logic                  type_known;
  } result_t;

  // per-request control carried beside the dividers
  typedef struct packed {
    logic             known;
    logic             zero_rate;
    logic             use_data;
    logic [1:0]       ctrl_sel;
    logic [OVH_W-1:0] ovh;
  } side_t;

  function automatic logic [7:0] preamble_usec(input logic [MODE_W-1:0] mode);
    logic [7:0] p;
    unique case (mode)
      MODE_DEFAULT: p = 8'd192;
      MODE_OFDM_A:  p = 8'd20;
      MODE_DSSS_B:  p = 8'd192;
      MODE_MIXED:   p = 8'd192;
      default:      p = 8'd192;
    endcase
    return p;
  endfunction

  function automatic logic [4:0] sifs_usec(input logic [MODE_W-1:0] mode);
    logic [4:0] s;
    unique case (mode)
      MODE_DEFAULT: s = 5'd10;
      MODE_OFDM_A:  s = 5'd16;
      MODE_DSSS_B:  s = 5'd10;
      MODE_MIXED:   s = 5'd16;
      default:      s = 5'd10;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/wfac_div.sv]
// pipelined restoring divider, BPS quotient bits per stage
module wfac_div
  import wfac_pkg::*;
#(
  parameter int DW  = DIV_W,
  parameter int VW  = RATE_W,
  parameter int BPS = DIV_BPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  output logic          out_valid,
  output logic [DW-1:0] out_quotient
);

  localparam int NS = (DW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  logic [VW-1:0] stage_rem [NS];
  logic [PW-1:0] stage_acc [NS];
  logic [VW-1:0] stage_dsr [NS];
  logic [NS-1:0] stage_vld;

  // BPS restoring steps: shift in a dividend bit, subtract when it fits
  function automatic logic [VW+PW-1:0] div_step(input logic [VW-1:0] rem_in,
                                                input logic [PW-1:0] acc_in,
                                                input logic [VW-1:0] dsr);
    logic [VW-1:0] rem;
    logic [PW-1:0] acc;
    logic [VW:0]   trial;
    rem = rem_in;
    acc = acc_in;
    for (int b = 0; b < BPS; b++) begin
      trial = {rem, acc[PW-1]};
      acc   = {acc[PW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial  = trial - {1'b0, dsr};
        acc[0] = 1'b1;
      end
      rem = trial[VW-1:0];
    end
    return {rem, acc};
  endfunction

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [VW-1:0]    rem_in;
    logic [PW-1:0]    acc_in;
    logic [VW-1:0]    dsr_in;
    logic             vld_in;
    logic [VW+PW-1:0] step;

    // stage inputs come from the ports or the previous stage
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign acc_in = PW'(in_dividend);
      assign dsr_in = in_divisor;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = stage_rem[s-1];
      assign acc_in = stage_acc[s-1];
      assign dsr_in = stage_dsr[s-1];
      assign vld_in = stage_vld[s-1];
    end

    assign step = div_step(rem_in, acc_in, dsr_in);

    // stage registers
    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld[s] <= 1'b0;
      end else begin
        stage_vld[s] <= vld_in;
      end
      stage_rem[s] <= step[VW+PW-1:PW];
      stage_acc[s] <= step[PW-1:0];
      stage_dsr[s] <= dsr_in;
    end
  end

  assign out_valid    = stage_vld[NS-1];
  assign out_quotient = stage_acc[NS-1][DW-1:0];

endmodule

[hw/rtl/wlan_frame_airtime_calc.sv]
// top level of the frame airtime calculator: config registers and pipeline
// Computes the transmit airtime of one 802.11 frame in whole microseconds from a
// message type and a payload byte count, using the configured modulation mode and
// unicast/multicast rates. A request is taken whenever start is high; busy never
// rises, so a new request may enter every cycle. Each request gives exactly one
// result, shown on result for one cycle with done high. In order, one stage forms
// the bit count times 1000, ceil(29 / DIV_BPS) stages run two restoring dividers
// side by side (payload bits and control frame bits), and two stages add the parts
// and register the result. The receiver cannot stall.
// A rate register holding zero makes any duration that uses it saturate to all ones.
// Registers: 0 modulation_mode, 1 unicast_rate_kbps, 2 multicast_rate_kbps, at
// byte addresses 0, 4 and 8; they must be written only while no request is in flight,
// but the block itself does not enforce this.
module wlan_frame_airtime_calc
  import wfac_pkg::*;
#(
  parameter int DIV_BPS = DIV_BPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  // result channel
  output logic                  done,
  output result_t               result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DIV_STAGES = (DIV_W + DIV_BPS - 1) / DIV_BPS;
  localparam int LATENCY    = DIV_STAGES + 3;

  logic [MODE_W-1:0] modulation_mode;
  logic [RATE_W-1:0] unicast_rate_kbps;
  logic [RATE_W-1:0] multicast_rate_kbps;

  logic              accept;
  logic [1:0]        reg_index;

  // prep stage signals
  side_t             prep_side_next;
  logic [BITS_W-1:0] prep_bits;
  logic [29:0]       prep_product;
  logic [RATE_W-1:0] prep_divisor_next;
  logic [7:0]        pre_usec;
  logic [4:0]        sifs;

  logic              prep_vld;
  side_t             prep_side;
  logic [DIV_W-1:0]  prep_dividend;
  logic [RATE_W-1:0] prep_divisor;

  // divider outputs and side line
  logic              data_vld;
  logic              ctrl_vld;
  logic [DIV_W-1:0]  data_quot;
  logic [DIV_W-1:0]  ctrl_quot;
  side_t             side_line [DIV_STAGES];
  side_t             side_out;

  // sum stages
  logic [DURATION_W-1:0] data_term;
  logic [DURATION_W-1:0] ctrl_term;
  logic                  sum_vld;
  side_t                 sum_side;
  logic [DURATION_W-1:0] sum_part1;
  logic [DURATION_W-1:0] sum_part2;
  result_t               result_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_mode     <= MODE_RESET;
      unicast_rate_kbps   <= RATE_RESET;
      multicast_rate_kbps <= RATE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_MODE:  modulation_mode     <= pwdata[MODE_W-1:0];
        REG_UCAST: unicast_rate_kbps   <= pwdata[RATE_W-1:0];
        REG_MCAST: multicast_rate_kbps <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (reg_index)
      REG_MODE:  prdata = APB_DATA_W'(modulation_mode);
      REG_UCAST: prdata = APB_DATA_W'(unicast_rate_kbps);
      REG_MCAST: prdata = APB_DATA_W'(multicast_rate_kbps);
      default:   prdata = '0;
    endcase
  end

  // decode the message type into overhead, divisor and bit count
  always_comb begin
    pre_usec                = preamble_usec(modulation_mode);
    sifs                    = sifs_usec(modulation_mode);
    prep_side_next.known    = 1'b1;
    prep_side_next.use_data = 1'b1;
    prep_side_next.ctrl_sel = CTRL_NONE;
    prep_side_next.ovh      = '0;
    prep_side_next.zero_rate = (unicast_rate_kbps == '0);
    prep_divisor_next       = unicast_rate_kbps;
    prep_bits = BITS_W'(DATA_HDR_BITS + ACK_BITS) + BITS_W'({req.byte_count, 3'b000});
    unique case (req.msg_type)
      MSG_CTS: begin
        prep_side_next.use_data = 1'b0;
        prep_side_next.ctrl_sel = CTRL_SINGLE;
        prep_side_next.ovh      = OVH_W'(pre_usec);
      end
      MSG_UNICAST: begin
        prep_side_next.ovh = OVH_W'(sifs) + OVH_W'({pre_usec, 1'b0});
      end
      MSG_RTS_CTS: begin
        prep_side_next.ctrl_sel = CTRL_DOUBLE;
        prep_side_next.ovh      = OVH_W'(sifs) + OVH_W'({pre_usec, 2'b00});
      end
      MSG_BCAST: begin
        prep_side_next.ovh       = OVH_W'(pre_usec);
        prep_side_next.zero_rate = (multicast_rate_kbps == '0);
        prep_divisor_next        = multicast_rate_kbps;
        prep_bits = BITS_W'(DATA_HDR_BITS) + BITS_W'({req.byte_count, 3'b000});
      end
      default: begin
        prep_side_next.known     = 1'b0;
        prep_side_next.use_data  = 1'b0;
        prep_side_next.zero_rate = 1'b0;
      end
    endcase
    prep_product = 30'(prep_bits) * 30'(KBPS_SCALE);
  end

  // prep stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_vld <= 1'b0;
    end else begin
      prep_vld <= accept;
    end
    prep_side     <= prep_side_next;
    prep_dividend <= prep_product[DIV_W-1:0];
    prep_divisor  <= prep_divisor_next;
  end

  // payload bits divided by the selected rate
  wfac_div #(
    .DW  (DIV_W),
    .VW  (RATE_W),
    .BPS (DIV_BPS)
  ) u_data_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (prep_vld),
    .in_dividend  (prep_dividend),
    .in_divisor   (prep_divisor),
    .out_valid    (data_vld),
    .out_quotient (data_quot)
  );

  // control frame bits divided by the unicast rate
  wfac_div #(
    .DW  (DIV_W),
    .VW  (RATE_W),
    .BPS (DIV_BPS)
  ) u_ctrl_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (prep_vld),
    .in_dividend  (CTRL_DIVIDEND),
    .in_divisor   (unicast_rate_kbps),
    .out_valid    (ctrl_vld),
    .out_quotient (ctrl_quot)
  );

  // side info travels beside the dividers
  always_ff @(posedge clk) begin
    side_line[0] <= prep_side;
    for (int i = 1; i < DIV_STAGES; i++) begin
      side_line[i] <= side_line[i-1];
    end
  end
  assign side_out = side_line[DIV_STAGES-1];

  // pick the quotient terms
  always_comb begin
    data_term = side_out.use_data ? DURATION_W'(data_quot) : '0;
    unique case (side_out.ctrl_sel)
      CTRL_SINGLE: ctrl_term = DURATION_W'(ctrl_quot);
      CTRL_DOUBLE: ctrl_term = DURATION_W'({ctrl_quot, 1'b0});
      default:     ctrl_term = '0;
    endcase
  end

  // first sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= data_vld && ctrl_vld;
    end
    sum_side  <= side_out;
    sum_part1 <= data_term + DURATION_W'(side_out.ovh);
    sum_part2 <= ctrl_term;
  end

  // final sum with unknown type and zero rate handling
  always_comb begin
    result_next.type_known = sum_side.known;
    if (!sum_side.known) begin
      result_next.duration_usec = '0;
    end else if (sum_side.zero_rate) begin
      result_next.duration_usec = DUR_MAX;
    end else begin
      result_next.duration_usec = sum_part1 + sum_part2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sum_vld;
    end
    result <= result_next;
  end

  // every result traces back to an accepted request
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching request");

  // type flag follows the request's message type
  a_type_known: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.type_known ==
              ($past(req.msg_type, LATENCY) <= MSG_BCAST)))
    else $error("type_known does not match request type");

  // unknown types give zero duration
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.type_known |-> result.duration_usec == '0)
    else $error("unknown type with nonzero duration");

  // known types always include at least one preamble or sifs
  a_known_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.type_known |-> result.duration_usec != '0)
    else $error("known type with zero duration");

  // both dividers stay in step
  a_div_aligned: assert property (@(posedge clk) disable iff (rst)
    data_vld == ctrl_vld)
    else $error("divider pipelines out of step");

endmodule
